// File: rtl/u8s_pkg.sv
// Shared types, constants and helpers for the UTF-8 sanitizer.
// The command word that passes from the front end to the back end through the queue.
// No dependencies.
package u8s_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_VAL   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// repl_cnt replacement characters first, then lit_cnt literal bytes
	typedef struct packed {
		logic [2:0]      repl_cnt;
		logic [2:0]      lit_cnt;
		logic [3:0][7:0] lits;
		logic            fin;
	} cmd_t;

	// continuation bytes that a lead needs; zero when the byte is no lead
	function automatic logic [1:0] lead_need(input logic [7:0] b);
		logic [1:0] need;
		begin
			if ((b & LEAD2_MASK) == LEAD2_VAL) need = 2'd1;
			else if ((b & LEAD3_MASK) == LEAD3_VAL) need = 2'd2;
			else if ((b & LEAD4_MASK) == LEAD4_VAL) need = 2'd3;
			else need = 2'd0;
			return need;
		end
	endfunction

	function automatic logic [7:0] repl_byte(input logic [1:0] idx);
		logic [7:0] r;
		begin
			case (idx)
				2'd0: r = REPL_B0;
				2'd1: r = REPL_B1;
				default: r = REPL_B2;
			endcase
			return r;
		end
	endfunction

endpackage

// File: rtl/utf8_sanitizer_unit.sv
// Top level of the UTF-8 sanitizer: front end, command queue, back end.
// Depends on u8s_pkg, u8s_front, u8s_queue, u8s_back.
//
// Repairs a byte stream into valid UTF-8, one input word per byte with a flag on
// the last byte of each string. The front end takes one input word per cycle
// while the four-entry command queue has room, and turns it into one command;
// a byte that only extends an open sequence makes none. The back end emits one
// output word per cycle from the head command while the output is not stalled;
// a command yields one byte for ASCII, three for each replacement character
// EF BF BD, two to four for a completed sequence, at most twelve. The output
// register holds a word under stall while the front end keeps accepting.
module utf8_sanitizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_done
);

	logic          q_full, accept, push, pop, head_valid;
	u8s_pkg::cmd_t push_cmd, head_cmd;

	assign in_stall = q_full;

	u8s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.accept     (accept),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	u8s_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	u8s_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.string_done (string_done)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (accept && !q_full))
		else $error("push into full queue");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_done) |-> run_end)
		else $error("string end without run end");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !head_valid) |=> !out_valid)
		else $error("output word without command");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> head_valid)
		else $error("full queue with no head");

endmodule

// File: rtl/u8s_front.sv
// Front end: accepts input words, tracks the open multibyte sequence and
// turns each word into at most one command word for the back end.
// Depends on u8s_pkg.
module u8s_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            final_byte,
	input  logic            q_full,
	output logic            accept,
	output logic            push,
	output u8s_pkg::cmd_t   push_cmd
);

	logic [1:0]      pc_q, need_q, pc_n, need_n, fresh_need;
	logic [2:0][7:0] pend_q, pend_n;
	logic [2:0]      repl, litc;
	logic [3:0][7:0] lits;
	logic            cont;

	assign accept     = in_valid && !q_full;
	assign cont       = (in_byte & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_VAL;
	assign fresh_need = u8s_pkg::lead_need(in_byte);

	always_comb begin
		pc_n   = pc_q;
		need_n = need_q;
		pend_n = pend_q;
		repl   = 3'd0;
		litc   = 3'd0;
		lits   = {4{in_byte}};
		if (pc_q == 2'd0 || !cont) begin
			repl   = {1'b0, pc_q};
			pc_n   = 2'd0;
			need_n = 2'd0;
			if (!in_byte[7]) begin
				litc = 3'd1;
			end else if (fresh_need != 2'd0) begin
				pend_n[0] = in_byte;
				pc_n      = 2'd1;
				need_n    = fresh_need;
			end else begin
				repl = repl + 3'd1;
			end
		end else if (pc_q >= need_q) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < pc_q) lits[k] = pend_q[k];
			end
			litc   = {1'b0, pc_q} + 3'd1;
			pc_n   = 2'd0;
			need_n = 2'd0;
		end else begin
			case (pc_q)
				2'd1: pend_n[1] = in_byte;
				default: pend_n[2] = in_byte;
			endcase
			pc_n = pc_q + 2'd1;
		end
		if (final_byte && pc_n != 2'd0) begin
			repl   = repl + {1'b0, pc_n};
			pc_n   = 2'd0;
			need_n = 2'd0;
		end
	end

	assign push              = accept && (repl != 3'd0 || litc != 3'd0);
	assign push_cmd.repl_cnt = repl;
	assign push_cmd.lit_cnt  = litc;
	assign push_cmd.lits     = lits;
	assign push_cmd.fin      = final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= 2'd0;
			need_q <= 2'd0;
		end else if (accept) begin
			pc_q   <= pc_n;
			need_q <= need_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) pend_q <= pend_n;
	end

endmodule

// File: rtl/u8s_queue.sv
// Command queue between front and back end, QDEPTH entries.
// Depends on u8s_pkg.
module u8s_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  u8s_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output u8s_pkg::cmd_t head_cmd
);

	localparam int AW = u8s_pkg::QAW;

	u8s_pkg::cmd_t mem_q [u8s_pkg::QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full       = cnt_q == (AW+1)'(u8s_pkg::QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + (AW+1)'(1);
				2'b01: cnt_q <= cnt_q - (AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

// File: rtl/u8s_back.sv
// Back end: expands the head command into output words, one per cycle while
// the output is not stalled, into a registered output stage.
// Depends on u8s_pkg.
module u8s_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  u8s_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          run_end,
	output logic          string_done
);

	logic [1:0] sub_q, lit_q;
	logic [2:0] rep_q;
	logic       in_repl, last, load;
	logic [7:0] cur_byte;

	assign load    = head_valid && (!out_valid || !out_stall);
	assign in_repl = rep_q != head_cmd.repl_cnt;

	always_comb begin
		if (in_repl) begin
			cur_byte = u8s_pkg::repl_byte(sub_q);
			last     = sub_q == 2'd2 && (rep_q + 3'd1) == head_cmd.repl_cnt
			           && head_cmd.lit_cnt == 3'd0;
		end else begin
			cur_byte = head_cmd.lits[lit_q];
			last     = ({1'b0, lit_q} + 3'd1) == head_cmd.lit_cnt;
		end
	end

	assign pop = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q     <= 2'd0;
			rep_q     <= 3'd0;
			lit_q     <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				if (last) begin
					sub_q <= 2'd0;
					rep_q <= 3'd0;
					lit_q <= 2'd0;
				end else if (in_repl) begin
					if (sub_q == 2'd2) begin
						sub_q <= 2'd0;
						rep_q <= rep_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end else begin
					lit_q <= lit_q + 2'd1;
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= cur_byte;
			run_end     <= last;
			string_done <= last && head_cmd.fin;
		end
	end

endmodule
